/* hdl/mrr_pkg.sv */
package mrr_pkg;

   localparam int ROUTE_DEPTH = 256;
   localparam int STAGES      = 2;

   localparam int ACT_W     = 2;
   localparam int TURN_W    = 2;
   localparam int IDX_W     = 8;
   localparam int LEN_W     = 9;
   localparam int CNT_W     = $clog2(ROUTE_DEPTH + 1);
   localparam int OFF_W     = $clog2(ROUTE_DEPTH);
   localparam int SEL_W     = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam int MEM_DEPTH = STAGES * ROUTE_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   typedef logic [TURN_W-1:0] turn_type;

   localparam turn_type TURN_STRAIGHT = 2'd0;
   localparam turn_type TURN_RIGHT    = 2'd1;
   localparam turn_type TURN_BACK     = 2'd2;
   localparam turn_type TURN_LEFT     = 2'd3;

   localparam logic [ACT_W-1:0] ACT_JUNCTION = 2'd0;
   localparam logic [ACT_W-1:0] ACT_APPEND   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ     = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_FETCH1,
      ST_SUM,
      ST_READ,
      ST_READ_DATA,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic do_append;
      logic do_read;
      logic full;
      logic can_shorten;
      logic prev_back;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic load_req;
      logic write_new;
      logic issue_prev1;
      logic issue_prev2;
      logic write_sum;
      logic issue_read;
      logic take_read;
      logic load_rsp;
   } ctrl_type;

   function automatic turn_type pick_turn(input logic lhr, input logic l,
                                          input logic f, input logic r);
      turn_type t;
      if (lhr) begin
         if (l)      t = TURN_LEFT;
         else if (f) t = TURN_STRAIGHT;
         else if (r) t = TURN_RIGHT;
         else        t = TURN_BACK;
      end else begin
         if (r)      t = TURN_RIGHT;
         else if (f) t = TURN_STRAIGHT;
         else if (l) t = TURN_LEFT;
         else        t = TURN_BACK;
      end
      return t;
   endfunction

endpackage

/* hdl/mrr_ram.sv */
module mrr_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/mrr_ctrl.sv */
module mrr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  mrr_pkg::status_type  status,
   output mrr_pkg::ctrl_type    ctl,
   output logic                 busy
);
   import mrr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.accept) begin
               if (status.do_append && !status.full) begin
                  state_in = ST_WRITE;
               end else if (status.do_read) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_WRITE: begin
            state_in = status.can_shorten ? ST_FETCH1 : ST_FINISH;
         end
         ST_FETCH1: begin
            state_in = status.prev_back ? ST_SUM : ST_FINISH;
         end
         ST_SUM:       state_in = ST_FINISH;
         ST_READ:      state_in = ST_READ_DATA;
         ST_READ_DATA: state_in = ST_FINISH;
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy         = 1'b0;
            ctl.load_req = status.accept;
         end
         ST_WRITE: begin
            ctl.write_new   = 1'b1;
            ctl.issue_prev1 = 1'b1;
         end
         ST_FETCH1:    ctl.issue_prev2 = 1'b1;
         ST_SUM:       ctl.write_sum = 1'b1;
         ST_READ:      ctl.issue_read = 1'b1;
         ST_READ_DATA: ctl.take_read = 1'b1;
         ST_FINISH:    ctl.load_rsp = status.out_free;
         default:      ctl = '0;
      endcase
   end

   a_sum_after_back_check: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |-> $past(state_ff) == ST_FETCH1)
      else $error("shortening sum without a back check");

   a_fetch_follows_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH1 |-> $past(state_ff) == ST_WRITE)
      else $error("prior entry fetch without a new write");

endmodule

/* hdl/maze_route_recorder.sv */
// Records up to two routes of turns (0 straight, 1 right, 2 back, 3 left) in one 512 x 2 route
// memory and shortens a route whenever its second-to-last turn is back and it held at least two
// turns before the append. One transaction is handled at a time and gives one result; req_stall
// is high while it is worked on, and the result register lets the next transaction in while a
// result still waits on rsp_stall. A dropped append or an unused action goes straight to the
// finish state; an append writes the new turn and, if it can shorten, checks the second-to-last
// entry and writes the sum when it is back; a read issues the read and then takes the data. The
// single read port of the route memory fetches the two prior entries one after the other. The
// route memory needs no clearing pass after reset; only the lengths are cleared.
module maze_route_recorder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mrr_pkg::ACT_W-1:0]     req_action,
   input  logic                          req_stage,
   input  logic                          req_left_open,
   input  logic                          req_forward_open,
   input  logic                          req_right_open,
   input  logic [mrr_pkg::TURN_W-1:0]    req_given_turn,
   input  logic [mrr_pkg::IDX_W-1:0]     req_read_index,
   input  logic                          req_mirror,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mrr_pkg::TURN_W-1:0]    rsp_turn_out,
   output logic [mrr_pkg::LEN_W-1:0]     rsp_route_length,
   output logic                          rsp_overflow
);
   import mrr_pkg::*;

   status_type status;
   ctrl_type   ctl;
   logic       busy;

   logic                lhr_ff;
   logic [CNT_W-1:0]    count_ff [STAGES];
   logic [CNT_W-1:0]    count_in [STAGES];
   logic [SEL_W-1:0]    stage_ff;
   logic [CNT_W-1:0]    n0_ff;
   turn_type            turn_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic                mirror_ff;
   logic                ovf_ff;

   logic                rsp_valid_ff;
   turn_type            rsp_turn_ff;
   logic [LEN_W-1:0]    rsp_length_ff;
   logic                rsp_overflow_ff;

   logic [SEL_W-1:0]    stage_sel;
   logic [CNT_W-1:0]    port_count;
   logic                do_append;
   turn_type            new_turn;
   turn_type            rd_data;
   turn_type            read_turn;
   turn_type            sum_turn;
   logic [ADDR_W-1:0]   base_addr;
   logic [OFF_W-1:0]    wr_off;
   logic [OFF_W-1:0]    rd_off;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   turn_type            wr_data;

   // a stage number beyond the store count selects stage 0
   assign stage_sel  = (32'(req_stage) >= STAGES) ? '0 : SEL_W'(req_stage);
   assign port_count = count_ff[stage_sel];
   assign do_append  = (req_action == ACT_JUNCTION) || (req_action == ACT_APPEND);

   always_comb begin
      case (req_action)
         ACT_JUNCTION: new_turn = pick_turn(lhr_ff, req_left_open, req_forward_open,
                                            req_right_open);
         ACT_APPEND:   new_turn = req_given_turn;
         default:      new_turn = TURN_STRAIGHT;
      endcase
   end

   assign req_stall = busy;

   always_comb begin
      status             = '0;
      status.accept      = req_valid && !busy;
      status.do_append   = do_append;
      status.do_read     = (req_action == ACT_READ);
      status.full        = (port_count >= CNT_W'(ROUTE_DEPTH));
      status.can_shorten = (n0_ff >= CNT_W'(2));
      status.prev_back   = (rd_data == TURN_BACK);
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   mrr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl),
      .busy   (busy)
   );

   // shared address and turn arithmetic
   assign base_addr = ADDR_W'(stage_ff) * ADDR_W'(ROUTE_DEPTH);
   assign wr_off    = ctl.write_sum ? OFF_W'(n0_ff - CNT_W'(2)) : OFF_W'(n0_ff);
   assign wr_addr   = base_addr + ADDR_W'(wr_off);
   assign rd_addr   = base_addr + ADDR_W'(rd_off);
   assign sum_turn  = turn_ff + TURN_BACK + rd_data;
   assign wr_en     = ctl.write_new || ctl.write_sum;
   assign wr_data   = ctl.write_sum ? sum_turn : turn_ff;

   always_comb begin
      rd_off = OFF_W'(idx_ff);
      if (ctl.issue_prev1) begin
         rd_off = OFF_W'(n0_ff - CNT_W'(1));
      end else if (ctl.issue_prev2) begin
         rd_off = OFF_W'(n0_ff - CNT_W'(2));
      end
   end

   always_comb begin
      read_turn = TURN_STRAIGHT;
      if (32'(idx_ff) < ROUTE_DEPTH) begin
         read_turn = rd_data;
      end
      if (mirror_ff && (read_turn == TURN_RIGHT || read_turn == TURN_LEFT)) begin
         read_turn = read_turn ^ (TURN_RIGHT ^ TURN_LEFT);
      end
   end

   mrr_ram #(
      .WIDTH (TURN_W),
      .DEPTH (MEM_DEPTH)
   ) u_route_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in = count_ff;
      if (ctl.write_new) begin
         count_in[stage_ff] = n0_ff + CNT_W'(1);
      end else if (ctl.write_sum) begin
         count_in[stage_ff] = n0_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lhr_ff       <= 1'b0;
         count_ff     <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            lhr_ff <= csr_wr_data;
         end
         count_ff <= count_in;
         if (ctl.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         stage_ff  <= stage_sel;
         n0_ff     <= port_count;
         turn_ff   <= new_turn;
         idx_ff    <= req_read_index;
         mirror_ff <= req_mirror;
         ovf_ff    <= do_append && status.full;
      end else if (ctl.take_read) begin
         turn_ff <= read_turn;
      end
      if (ctl.load_rsp) begin
         rsp_turn_ff     <= turn_ff;
         rsp_length_ff   <= LEN_W'(count_ff[stage_ff]);
         rsp_overflow_ff <= ovf_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_turn_out     = rsp_turn_ff;
   assign rsp_route_length = rsp_length_ff;
   assign rsp_overflow     = rsp_overflow_ff;

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   a_length_in_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> count_ff[stage_ff] <= CNT_W'(ROUTE_DEPTH))
      else $error("route length beyond store depth");

   a_shorten_length: assert property (@(posedge clock) disable iff (reset)
      ctl.write_sum |=> count_ff[$past(stage_ff)] == $past(n0_ff) - CNT_W'(1))
      else $error("shortening did not drop the length by two");

endmodule
